>>> src/itra_pkg.sv
// Shared types, constants and the digit-to-ASCII function for the radix text converter.
package itra_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int NUMBER_W    = 32;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int DIGIT_W     = RADIX_W;
    localparam int STEP_W      = $clog2(VALUE_WIDTH);
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);

    localparam logic [CHAR_W-1:0]  CHAR_MINUS  = CHAR_W'(45);
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  CHAR_LETTER = CHAR_W'(55);
    localparam logic [DIGIT_W-1:0] DIGIT_TEN   = DIGIT_W'(10);

    typedef struct packed {
        logic signed [NUMBER_W-1:0] number;
        logic [RADIX_W-1:0]         radix;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last_char;
    } out_t;

    typedef struct packed {
        logic load;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = CHAR_W'(d);
        if (d < DIGIT_TEN)
            return ext + CHAR_ZERO;
        else
            return ext + CHAR_LETTER;
    endfunction

endpackage

>>> src/itra_div.sv
// Bit-serial restoring divider: one quotient bit per cycle by a small radix.
module itra_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  itra_pkg::div_ctl_t                 ctl,
    input  logic [itra_pkg::VALUE_WIDTH-1:0]   dividend,
    input  logic [itra_pkg::RADIX_W-1:0]       base,
    output itra_pkg::div_stat_t                stat,
    output logic [itra_pkg::VALUE_WIDTH-1:0]   quotient,
    output logic [itra_pkg::DIGIT_W-1:0]       remainder
);
    import itra_pkg::*;

    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [DIGIT_W-1:0]     rem_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   active_reg;
    logic                   done_reg;

    logic [DIGIT_W:0]       trial;
    logic [DIGIT_W:0]       base_ext;
    logic                   fits;
    logic [DIGIT_W-1:0]     rem_next;

    assign trial    = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign base_ext = {1'b0, base};
    assign fits     = trial >= base_ext;
    assign rem_next = fits ? DIGIT_W'(trial - base_ext) : DIGIT_W'(trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.load)
            begin
                active_reg <= 1'b1;
                step_reg   <= '0;
            end
            else if (active_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(VALUE_WIDTH - 1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (active_reg)
        begin
            quo_reg <= {quo_reg[VALUE_WIDTH-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = active_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> src/int_to_radix_ascii.sv
// Top level: integer to ASCII text in radix 2 to 36, most significant digit first.
// The number is read as signed in radix 10 and as unsigned in every other radix.
//   channel    handshake       payload             transfer at
//   input      start / busy    operand (in_t)      rising edge with start high, busy low
//   output     strobe          result (out_t)      rising edge ending the strobe cycle
//
// Each digit is the remainder of a full division in the bit-serial divider, and the
// quotient is divided again until it is zero; the characters then leave the digit
// stack back to back, after a '-' sign if there is one.
// Reset clears the sequencer and the divider control; no item is pending after it.
// The receiver cannot stall: every character is shown for exactly one cycle.
module int_to_radix_ascii (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  itra_pkg::in_t   operand,
    output logic            busy,
    output logic            strobe,
    output itra_pkg::out_t  result
);
    import itra_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_SIGN,
        S_EMIT
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   minus_reg;
    logic [RADIX_W-1:0]     base_reg;
    logic                   strobe_reg;
    out_t                   result_reg;
    logic [DIGIT_W-1:0]     digits_reg [VALUE_WIDTH];

    logic                   accept;
    logic [RADIX_W-1:0]     base_sat;
    logic [VALUE_WIDTH-1:0] raw;
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   push;
    logic                   pop;
    logic                   quo_zero;

    div_ctl_t               div_ctl;
    div_stat_t              div_stat;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [DIGIT_W-1:0]     div_rem;

    assign accept = start && (state_reg == S_IDLE);

    always_comb
    begin
        priority if (operand.radix < RADIX_MIN)
            base_sat = RADIX_MIN;
        else if (operand.radix > RADIX_MAX)
            base_sat = RADIX_MAX;
        else
            base_sat = operand.radix;
    end

    assign raw = VALUE_WIDTH'(operand.number);
    assign neg = (base_sat == RADIX_DEC) && raw[VALUE_WIDTH-1];
    assign mag = neg ? (~raw + VALUE_WIDTH'(1)) : raw;

    assign quo_zero     = (div_quo == '0);
    assign push         = (state_reg == S_DIVIDE) && div_stat.done;
    assign pop          = (state_reg == S_EMIT);
    assign div_ctl.load = accept || (push && !quo_zero);
    assign div_dividend = accept ? mag : div_quo;

    itra_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (div_dividend),
        .base      (base_reg),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            minus_reg  <= 1'b0;
            base_reg   <= RADIX_MIN;
            strobe_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_DIVIDE;
                        minus_reg <= neg;
                        base_reg  <= base_sat;
                        count_reg <= '0;
                    end
                end
                S_DIVIDE:
                begin
                    if (div_stat.done)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                        if (quo_zero)
                            state_reg <= minus_reg ? S_SIGN : S_EMIT;
                    end
                end
                S_SIGN:
                begin
                    strobe_reg           <= 1'b1;
                    result_reg.character <= CHAR_MINUS;
                    result_reg.last_char <= 1'b0;
                    state_reg            <= S_EMIT;
                end
                S_EMIT:
                begin
                    strobe_reg           <= 1'b1;
                    result_reg.character <= digit_char(digits_reg[0]);
                    result_reg.last_char <= (count_reg == CNT_W'(1));
                    count_reg            <= count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                        state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // push the newest digit on top, pop from the top
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            digits_reg[0] <= div_rem;
            for (int i = 1; i < VALUE_WIDTH; i++)
                digits_reg[i] <= digits_reg[i-1];
        end
        else if (pop)
        begin
            for (int i = 0; i < VALUE_WIDTH - 1; i++)
                digits_reg[i] <= digits_reg[i+1];
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.load |-> !div_stat.busy)
        else $error("divider loaded while running");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after input transfer");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last_char) |=> !strobe)
        else $error("character transfer right after final character");

    a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (count_reg != '0))
        else $error("digit stack empty while emitting");

endmodule

>>> sim/int_to_radix_ascii_test.sv
// Self-checking testbench for int_to_radix_ascii: random and corner numbers and radixes.
module int_to_radix_ascii_test;

    import itra_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    in_t  operand = '0;
    logic busy;
    logic strobe;
    out_t result;

    in_t  number_queue[$];
    out_t pending_text[$];
    bit   taken = 1'b1;
    int   mismatches = 0;
    int   burst_left = 0;
    int   gap_left = 0;

    int_to_radix_ascii dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .operand(operand),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    always #5 clk = ~clk;

    function automatic void render_text(input in_t op);
        logic [31:0]       mag;
        int unsigned       base;
        logic [CHAR_W-1:0] digits[0:33];
        logic [CHAR_W-1:0] d;
        int                n;
        out_t              c;
        base = 32'(op.radix);
        if (base < 2)
            base = 2;
        if (base > 36)
            base = 36;
        mag = op.number;
        n = 0;
        if (base == 10 && mag[31])
        begin
            mag = -mag;
            c.character = CHAR_MINUS;
            c.last_char = 1'b0;
            pending_text.push_back(c);
        end
        do
        begin
            d = CHAR_W'(mag % base);
            digits[n] = (d < 10) ? d + CHAR_ZERO : d + CHAR_LETTER;
            n++;
            mag = mag / base;
        end
        while (mag != 0);
        for (int k = n - 1; k >= 0; k--)
        begin
            c.character = digits[k];
            c.last_char = (k == 0);
            pending_text.push_back(c);
        end
    endfunction

    task automatic queue_number(input logic [31:0] value, input logic [RADIX_W-1:0] base);
        in_t op;
        op.number = value;
        op.radix = base;
        number_queue.push_back(op);
    endtask

    // drive the command side in bursts with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !taken)
            start <= 1'b1;
        else if (gap_left > 0)
        begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (number_queue.size() > 0)
        begin
            operand <= number_queue.pop_front();
            start <= 1'b1;
            taken = 1'b0;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 6);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
            end
            else
                burst_left <= burst_left - 1;
        end
        else
            start <= 1'b0;
    end

    // check each character, then record any transfer on the command side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe)
            begin
                if (pending_text.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected character %0d last %0b",
                                 result.character, result.last_char);
                    mismatches++;
                end
                else
                begin
                    out_t want;
                    want = pending_text.pop_front();
                    if (result.character !== want.character
                        || result.last_char !== want.last_char)
                    begin
                        if (mismatches < 10)
                            $display("character mismatch: expected %0d last %0b, got %0d last %0b",
                                     want.character, want.last_char,
                                     result.character, result.last_char);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                render_text(operand);
                taken = 1'b1;
            end
        end
    end

    initial
    begin
        logic [31:0]        value;
        logic [RADIX_W-1:0] base;
        queue_number(32'd0, 6'd10);
        queue_number(32'd0, 6'd2);
        queue_number(32'h7FFFFFFF, 6'd2);
        queue_number(32'h7FFFFFFF, 6'd10);
        queue_number(32'h7FFFFFFF, 6'd36);
        queue_number(32'h80000000, 6'd10);
        queue_number(32'h80000000, 6'd2);
        queue_number(32'h80000000, 6'd16);
        queue_number(32'h80000000, 6'd36);
        queue_number(32'hFFFFFFFF, 6'd10);
        queue_number(32'hFFFFFFFF, 6'd16);
        queue_number(32'hFFFFFFFF, 6'd2);
        queue_number(32'd35, 6'd36);
        queue_number(32'd36, 6'd36);
        queue_number(32'd10, 6'd10);
        queue_number(-32'sd123, 6'd10);
        queue_number(32'd255, 6'd16);
        queue_number(32'd5, 6'd0);
        queue_number(32'd5, 6'd1);
        queue_number(32'd1295, 6'd37);
        queue_number(32'hDEADBEEF, 6'd63);
        queue_number(-32'sd7, 6'd7);
        for (int i = 0; i < 148; i++)
        begin
            case ($urandom_range(0, 4))
                0: value = $urandom_range(0, 40);
                1: value = -$urandom_range(1, 40);
                2: value = $urandom_range(0, 3) + ($urandom_range(0, 1) ? 32'h7FFFFFFC
                                                                          : 32'h80000000);
                3: value = $urandom_range(0, 65535) - 32768;
                default: value = $urandom;
            endcase
            base = ($urandom_range(0, 9) == 0) ? RADIX_W'($urandom_range(0, 63))
                                               : RADIX_W'($urandom_range(2, 36));
            queue_number(value, base);
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        do
            @(posedge clk);
        while (number_queue.size() != 0 || !taken || pending_text.size() != 0 || busy);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
